// ===== src/bed_pkg.sv =====
// Shared types, constants and control structs for the battery energy dispatcher.
// Used by every module under src; depends on nothing.
`default_nettype none

package bed_pkg;

    localparam int EnergyW = 24;
    localparam int LevelW  = 23;
    localparam int ProdW   = 48;
    localparam int QuotW   = 25;
    localparam int RemW    = 24;
    localparam int StepW   = 5;
    localparam int CfgIdxW = 2;

    localparam logic [StepW-1:0] DivSteps = StepW'(QuotW);

    // Levels are percent with 16 fraction bits.
    localparam logic [LevelW-1:0]  LvlFloor = 23'd65536;
    localparam logic [LevelW-1:0]  LvlCeil  = 23'd6488064;
    // Energy per level unit is capacity / PctScale.
    localparam logic [EnergyW-1:0] PctScale = 24'd6553600;

    localparam logic [EnergyW-1:0] CapReset   = 24'd160000;
    localparam logic [EnergyW-1:0] LimitReset = 24'd7800;
    localparam logic [LevelW-1:0]  LevelReset = 23'd3276800;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CAPACITY = 2'd0,
        REG_LIMIT    = 2'd1,
        REG_INIT_LVL = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [EnergyW-1:0] consumption_energy;
        logic [EnergyW-1:0] generation_energy;
    } in_item_t;

    typedef struct packed {
        logic [EnergyW-1:0] grid_purchase;
        logic [EnergyW-1:0] battery_discharge;
        logic [EnergyW-1:0] battery_charge;
        logic [EnergyW-1:0] grid_sale;
        logic [EnergyW-1:0] self_supply;
        logic [LevelW-1:0]  battery_level_pct;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic mul_span;
        logic div_init;
        logic div_step;
        logic div_by_cap;
        logic decide;
        logic scale;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_ceil;
        logic skip_scale;
        logic out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== src/battery_energy_dispatch.sv =====
// Top level of the battery energy dispatcher: configuration registers and wiring.
// Depends on bed_pkg, bed_ctrl and bed_datapath.
//
// Usage. Each beat on the s_ channel carries one metering interval's consumption
// and generation energy. The block answers every input beat with exactly one
// beat on the m_ channel holding purchase, discharge, charge, sale, self-supply
// and the new battery level. Items are processed one at a time.
//
// Sequence. A full item runs a level-span multiply, a 25-step serial division
// to turn the span into energy, and a second 25-step division to turn the moved
// energy back into a level change. The serial divider yields one quotient bit
// per cycle. When no rescale is needed (battery exhausted or nothing moved) the
// second division is skipped; a surplus with the level already at the ceiling
// skips both divisions.
//
// Stalls. The result sits in an output register, so the next input beat is
// accepted while a result waits; if the previous result is still not taken when
// the next one is ready, the block holds in its final step until m_ready.
//
// Reset. aresetn (synchronous, active low) loads the register reset values and
// sets the level to LevelReset. Writing the initial level register
// also reloads the level at once. The configuration port is ready outside reset
// and should be written only while the block is idle.
`default_nettype none

module battery_energy_dispatch (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire bed_pkg::in_item_t            s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output bed_pkg::out_item_t                m_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bed_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [bed_pkg::EnergyW-1:0]  cfg_data
);
    import bed_pkg::*;

    logic [EnergyW-1:0] capacity_reg;
    logic [EnergyW-1:0] limit_reg;
    logic               cfg_write;
    logic               level_load;
    ctrl_cmd_t          cmd;
    ctrl_sts_t          sts;

    assign cfg_ready  = aresetn;
    assign cfg_write  = cfg_valid && cfg_ready;
    // The initial level itself is only needed at the moment it is written, so
    // it goes straight into the level register inside the datapath.
    assign level_load = cfg_write && (cfg_index_t'(cfg_index) == REG_INIT_LVL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CapReset;
            limit_reg    <= LimitReset;
        end else if (cfg_write) begin
            unique case (cfg_index_t'(cfg_index))
                REG_CAPACITY: capacity_reg <= cfg_data;
                REG_LIMIT:    limit_reg    <= cfg_data;
                default: begin
                    // The initial level is handled above; other indexes are ignored.
                end
            endcase
        end
    end

    bed_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_valid),
        .item_ready (s_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    bed_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .item         (s_data),
        .capacity     (capacity_reg),
        .power_limit  (limit_reg),
        .level_load   (level_load),
        .level_value  (cfg_data[LevelW-1:0]),
        .result       (m_data),
        .result_valid (m_valid),
        .result_ready (m_ready)
    );

endmodule

`default_nettype wire

// ===== src/bed_div.sv =====
// Serial restoring divider, one quotient bit per step, shared by both conversions.
// Depends on bed_pkg. The dividend must be below divisor * 2**QuotW.
`default_nettype none

module bed_div (
    input  wire logic                         aclk,
    input  wire logic                         init,
    input  wire logic                         step,
    input  wire logic [bed_pkg::ProdW-1:0]    dividend,
    input  wire logic [bed_pkg::EnergyW-1:0]  divisor,
    output logic      [bed_pkg::QuotW-1:0]    quotient
);
    import bed_pkg::*;

    logic [RemW-1:0]  rem_reg, rem_next;
    logic [QuotW-1:0] quo_reg, quo_next;
    logic [RemW:0]    trial;
    logic [RemW:0]    diff;
    logic             fits;

    always_comb begin
        trial    = {rem_reg, quo_reg[QuotW-1]};
        diff     = trial - {1'b0, divisor};
        fits     = (trial >= {1'b0, divisor});
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (init) begin
            rem_next = RemW'(dividend[ProdW-1:QuotW]);
            quo_next = dividend[QuotW-1:0];
        end else if (step) begin
            rem_next = fits ? diff[RemW-1:0] : trial[RemW-1:0];
            quo_next = {quo_reg[QuotW-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/bed_datapath.sv =====
// Datapath: item registers, span multiplier, min/exhaustion logic, level update
// and the output register. Depends on bed_pkg and bed_div.
`default_nettype none

module bed_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bed_pkg::ctrl_cmd_t           cmd,
    output bed_pkg::ctrl_sts_t                sts,
    input  wire bed_pkg::in_item_t            item,
    input  wire logic [bed_pkg::EnergyW-1:0]  capacity,
    input  wire logic [bed_pkg::EnergyW-1:0]  power_limit,
    input  wire logic                         level_load,
    input  wire logic [bed_pkg::LevelW-1:0]   level_value,
    output bed_pkg::out_item_t                result,
    output logic                              result_valid,
    input  wire logic                         result_ready
);
    import bed_pkg::*;

    logic [EnergyW-1:0] gen_reg, diff_reg, amount_reg;
    logic [LevelW-1:0]  span_reg, level_reg;
    logic [ProdW-1:0]   prod_reg;
    logic               deficit_reg, at_ceil_reg, exhausted_reg, skip_reg;
    logic               valid_reg;
    out_item_t          out_reg;

    logic [QuotW-1:0]   quotient;
    logic               deficit;
    logic [LevelW-1:0]  span;
    logic [EnergyW-1:0] lim;
    logic               exhausted;
    logic [EnergyW-1:0] amount;
    logic [QuotW-1:0]   delta;
    logic [LevelW-1:0]  level_new;
    out_item_t          res;

    bed_div u_div (
        .aclk     (aclk),
        .init     (cmd.div_init),
        .step     (cmd.div_step),
        .dividend (prod_reg),
        .divisor  (cmd.div_by_cap ? capacity : PctScale),
        .quotient (quotient)
    );

    // Span of level to convert: above the floor on a deficit, below the ceiling on a surplus.
    always_comb begin
        deficit = (item.consumption_energy >= item.generation_energy);
        if (deficit) begin
            span = (level_reg > LvlFloor) ? level_reg - LvlFloor : '0;
        end else begin
            span = (level_reg >= LvlCeil) ? '0 : LvlCeil - level_reg;
        end
    end

    // Energy moved is the least of need, limit and what the battery can take or give.
    always_comb begin
        lim       = (diff_reg < power_limit) ? diff_reg : power_limit;
        exhausted = (quotient < {1'b0, lim});
        amount    = exhausted ? quotient[EnergyW-1:0] : lim;
    end

    always_comb begin
        delta = skip_reg ? '0 : quotient;
        res   = '0;
        if (deficit_reg) begin
            if (exhausted_reg) begin
                level_new = LvlFloor;
            end else if (level_reg >= LvlFloor) begin
                level_new = (QuotW'(level_reg - LvlFloor) > delta)
                          ? level_reg - delta[LevelW-1:0] : LvlFloor;
            end else begin
                level_new = level_reg;
            end
            res.grid_purchase     = diff_reg - amount_reg;
            res.battery_discharge = amount_reg;
        end else if (at_ceil_reg) begin
            level_new     = LvlCeil;
            res.grid_sale = diff_reg;
        end else begin
            if (exhausted_reg) begin
                level_new = LvlCeil;
            end else begin
                level_new = (QuotW'(LvlCeil - level_reg) > delta)
                          ? level_reg + delta[LevelW-1:0] : LvlCeil;
            end
            res.battery_charge = amount_reg;
            res.grid_sale      = diff_reg - amount_reg;
        end
        res.self_supply = gen_reg + res.battery_discharge - res.grid_sale
                        - res.battery_charge;
        res.battery_level_pct = level_new;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            gen_reg     <= item.generation_energy;
            deficit_reg <= deficit;
            at_ceil_reg <= !deficit && (level_reg >= LvlCeil);
            span_reg    <= span;
            diff_reg    <= deficit ? item.consumption_energy - item.generation_energy
                                   : item.generation_energy - item.consumption_energy;
        end
        if (cmd.mul_span) begin
            prod_reg <= ProdW'(span_reg) * ProdW'(capacity);
        end else if (cmd.scale) begin
            // amount * 6553600 + capacity / 2, with 6553600 = (64 + 32 + 4) << 16.
            prod_reg <= {2'b0, amount_reg, 22'b0} + {3'b0, amount_reg, 21'b0}
                      + {6'b0, amount_reg, 18'b0} + {25'b0, capacity[EnergyW-1:1]};
        end
        if (cmd.decide) begin
            amount_reg    <= amount;
            exhausted_reg <= exhausted;
            skip_reg      <= exhausted || (amount == '0);
        end
        if (cmd.finish) begin
            out_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LevelReset;
            valid_reg <= 1'b0;
        end else begin
            if (level_load) begin
                level_reg <= level_value;
            end else if (cmd.finish) begin
                level_reg <= level_new;
            end
            if (cmd.finish) begin
                valid_reg <= 1'b1;
            end else if (result_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign sts.at_ceil    = at_ceil_reg;
    assign sts.skip_scale = skip_reg;
    assign sts.out_free   = !valid_reg || result_ready;
    assign result         = out_reg;
    assign result_valid   = valid_reg;

endmodule

`default_nettype wire

// ===== src/bed_ctrl.sv =====
// Controller state machine sequencing multiply, two serial divisions and the update.
// Depends on bed_pkg.
`default_nettype none

module bed_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire bed_pkg::ctrl_sts_t   sts,
    output bed_pkg::ctrl_cmd_t        cmd
);
    import bed_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SPAN   = 9'b000000010,
        ST_LOAD1  = 9'b000000100,
        ST_DIV1   = 9'b000001000,
        ST_DECIDE = 9'b000010000,
        ST_SCALE  = 9'b000100000,
        ST_LOAD2  = 9'b001000000,
        ST_DIV2   = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             last_step;

    assign last_step = (step_reg == DivSteps - 1'b1);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // No beat is taken while reset is held.
                item_ready = aresetn;
                if (item_valid && item_ready) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_SPAN;
                end
            end
            ST_SPAN: begin
                cmd.mul_span = 1'b1;
                state_next   = sts.at_ceil ? ST_FINISH : ST_LOAD1;
            end
            ST_LOAD1: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV1;
            end
            ST_DIV1: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = sts.skip_scale ? ST_FINISH : ST_LOAD2;
            end
            ST_LOAD2: begin
                cmd.div_init   = 1'b1;
                cmd.div_by_cap = 1'b1;
                step_next      = '0;
                state_next     = ST_DIV2;
            end
            ST_DIV2: begin
                cmd.div_step   = 1'b1;
                cmd.div_by_cap = 1'b1;
                step_next      = step_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire
